/* rtl/core/rfft_pkg.sv */
package rfft_pkg;

    localparam int ADDR_W = 6;
    localparam int LG_W   = 3;
    localparam int CNT_W  = 7;

    localparam int MAX_POINTS_DEF    = 64;
    localparam int INNER_WIDTH_DEF   = 24;
    localparam int TWIDDLE_WIDTH_DEF = 16;

    localparam int INV_SQRT2_Q23 = 5931642;

    // cos(pi*k/32) in Q23, k = 0..16
    localparam int QUARTER_COS [17] = '{
        8388608, 8348215, 8227423, 8027397, 7750063, 7398092, 6974873, 6484482,
        5931642, 5321677, 4660461, 3954362, 3210181, 2435084, 1636536, 822227, 0
    };

    typedef enum logic [0:0] {
        CFG_INVERSE   = 1'b0,
        CFG_LOG2_SIZE = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        WSEL_LOAD = 2'd0,
        WSEL_SUM  = 2'd1,
        WSEL_DIFF = 2'd2
    } wsel_t;

    typedef struct packed {
        logic              smp_wr_en;
        logic [ADDR_W-1:0] smp_wr_addr;
        logic [ADDR_W-1:0] smp_rd_addr;
        logic              ld_zero;
        logic              wk_wr_en;
        wsel_t             wk_sel;
        logic [ADDR_W-1:0] wk_wr_addr;
        logic [ADDR_W-1:0] rd_a;
        logic [ADDR_W-1:0] rd_b;
        logic [ADDR_W-1:0] tw_idx;
        logic              mul_en;
        logic              diff_en;
        logic              out_mul_en;
        logic              out_load;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic out_valid;
    } status_t;

    // Cosine of pi*t/32 at tw bits, tw-1 fraction bits.
    function automatic int tw_cos(input logic [5:0] t, input int tw);
        int   idx;
        logic neg;
        int   m;
        int   s;
        int   maxc;
        if (t <= 6'd16) begin
            idx = int'(t);
            neg = 1'b0;
        end else if (t <= 6'd32) begin
            idx = 32 - int'(t);
            neg = 1'b1;
        end else if (t <= 6'd48) begin
            idx = int'(t) - 32;
            neg = 1'b1;
        end else begin
            idx = 64 - int'(t);
            neg = 1'b0;
        end
        m = QUARTER_COS[idx];
        s = 24 - tw;
        if (s > 0) begin
            m = (m + (1 << (s - 1))) >>> s;
        end
        maxc = (1 << (tw - 1)) - 1;
        if (m > maxc) begin
            m = maxc;
        end
        return neg ? -m : m;
    endfunction

    function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] i,
                                                 input logic [LG_W-1:0] lg);
        logic [ADDR_W-1:0] r;
        r = '0;
        for (int b = 0; b < ADDR_W; b++) begin
            if (b < int'(lg) && i[b]) begin
                r[3'(int'(lg) - 1 - b)] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

/* rtl/core/rfft_ctrl.sv */
module rfft_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        frame_end,
    input  logic [rfft_pkg::LG_W-1:0]   lg,
    input  rfft_pkg::status_t           status,
    output logic                        in_ready,
    output rfft_pkg::cmd_t              cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_BF_RD,
        S_BF_MUL,
        S_BF_WA,
        S_BF_WB,
        S_OUT_RD,
        S_OUT_MUL,
        S_OUT_RND
    } state_t;

    state_t                             state_reg;
    logic [rfft_pkg::CNT_W-1:0]         fill_count_reg;
    logic [rfft_pkg::ADDR_W-1:0]        idx_reg;
    logic [rfft_pkg::ADDR_W-1:0]        bfly_reg;
    logic [rfft_pkg::LG_W-1:0]          stage_reg;

    logic [rfft_pkg::CNT_W-1:0]         n_pts;
    logic [rfft_pkg::ADDR_W-1:0]        n_last;
    logic [rfft_pkg::ADDR_W-1:0]        bfly_last;
    logic [rfft_pkg::ADDR_W-1:0]        half;
    logic [rfft_pkg::ADDR_W-1:0]        mask;
    logic [rfft_pkg::ADDR_W-1:0]        k_idx;
    logic [rfft_pkg::ADDR_W-1:0]        addr_a;
    logic [rfft_pkg::ADDR_W-1:0]        rev_idx;

    always_comb
    begin
        n_pts     = rfft_pkg::CNT_W'(1) << lg;
        n_last    = rfft_pkg::ADDR_W'(n_pts - 1'b1);
        bfly_last = rfft_pkg::ADDR_W'((n_pts >> 1) - 1'b1);
        half      = rfft_pkg::ADDR_W'(1) << (stage_reg - 1'b1);
        mask      = half - 1'b1;
        k_idx     = bfly_reg & mask;
        addr_a    = ((bfly_reg & ~mask) << 1) | k_idx;
        rev_idx   = rfft_pkg::bit_rev(idx_reg, lg);
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd             = '0;
        cmd.smp_wr_en   = (state_reg == S_IDLE) && in_valid && (fill_count_reg < n_pts);
        cmd.smp_wr_addr = fill_count_reg[rfft_pkg::ADDR_W-1:0];
        cmd.smp_rd_addr = rev_idx;
        cmd.ld_zero     = ({1'b0, rev_idx} >= fill_count_reg);
        cmd.wk_sel      = rfft_pkg::WSEL_LOAD;
        cmd.wk_wr_addr  = idx_reg;
        cmd.rd_a        = idx_reg;
        cmd.rd_b        = addr_a | half;
        cmd.tw_idx      = rfft_pkg::ADDR_W'(k_idx << (3'd6 - stage_reg));
        cmd.last        = (idx_reg == n_last);
        case (state_reg)
            S_LD_WR:
            begin
                cmd.wk_wr_en = 1'b1;
            end
            S_BF_RD, S_BF_MUL:
            begin
                cmd.rd_a   = addr_a;
                cmd.mul_en = (state_reg == S_BF_MUL);
            end
            S_BF_WA:
            begin
                cmd.rd_a       = addr_a;
                cmd.wk_wr_en   = 1'b1;
                cmd.wk_sel     = rfft_pkg::WSEL_SUM;
                cmd.wk_wr_addr = addr_a;
                cmd.diff_en    = 1'b1;
            end
            S_BF_WB:
            begin
                cmd.rd_a       = addr_a;
                cmd.wk_wr_en   = 1'b1;
                cmd.wk_sel     = rfft_pkg::WSEL_DIFF;
                cmd.wk_wr_addr = addr_a | half;
            end
            S_OUT_MUL:
            begin
                cmd.out_mul_en = 1'b1;
            end
            S_OUT_RND:
            begin
                cmd.out_load = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_count_reg <= '0;
            idx_reg        <= '0;
            bfly_reg       <= '0;
            stage_reg      <= 3'd1;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (fill_count_reg < n_pts)
                        begin
                            fill_count_reg <= fill_count_reg + 1'b1;
                        end
                        if (frame_end)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_LD_RD;
                        end
                    end
                end
                S_LD_RD:
                begin
                    state_reg <= S_LD_WR;
                end
                S_LD_WR:
                begin
                    if (idx_reg == n_last)
                    begin
                        stage_reg <= 3'd1;
                        bfly_reg  <= '0;
                        state_reg <= S_BF_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_LD_RD;
                    end
                end
                S_BF_RD:
                begin
                    state_reg <= S_BF_MUL;
                end
                S_BF_MUL:
                begin
                    state_reg <= S_BF_WA;
                end
                S_BF_WA:
                begin
                    state_reg <= S_BF_WB;
                end
                S_BF_WB:
                begin
                    if (bfly_reg == bfly_last)
                    begin
                        bfly_reg <= '0;
                        if (stage_reg == lg)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_OUT_RD;
                        end
                        else
                        begin
                            stage_reg <= stage_reg + 1'b1;
                            state_reg <= S_BF_RD;
                        end
                    end
                    else
                    begin
                        bfly_reg  <= bfly_reg + 1'b1;
                        state_reg <= S_BF_RD;
                    end
                end
                S_OUT_RD:
                begin
                    if (!status.out_valid)
                    begin
                        state_reg <= S_OUT_MUL;
                    end
                end
                S_OUT_MUL:
                begin
                    state_reg <= S_OUT_RND;
                end
                S_OUT_RND:
                begin
                    if (idx_reg == n_last)
                    begin
                        fill_count_reg <= '0;
                        state_reg      <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_OUT_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT_RND) |-> !status.out_valid)
        else $error("bin loaded over a waiting result");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !cmd.wk_wr_en)
        else $error("work memory written while idle");

    a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT_RND && idx_reg == n_last)
        |=> (state_reg == S_IDLE && fill_count_reg == '0))
        else $error("frame did not close after last bin");

endmodule

/* rtl/core/rfft_dp.sv */
module rfft_dp #(
    parameter int MAX_POINTS    = rfft_pkg::MAX_POINTS_DEF,
    parameter int INNER_WIDTH   = rfft_pkg::INNER_WIDTH_DEF,
    parameter int TWIDDLE_WIDTH = rfft_pkg::TWIDDLE_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rfft_pkg::cmd_t            cmd,
    input  logic signed [15:0]        sample_re,
    input  logic signed [15:0]        sample_im,
    input  logic                      inverse,
    input  logic [rfft_pkg::LG_W-1:0] lg,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic signed [15:0]        result_re,
    output logic signed [15:0]        result_im,
    output logic                      saturated,
    output logic                      last_bin,
    output rfft_pkg::status_t         status
);

    localparam int IW   = INNER_WIDTH;
    localparam int TW   = TWIDDLE_WIDTH;
    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int FRAC = IW - 9;
    localparam int LSH  = (FRAC >= 15) ? FRAC - 15 : 0;
    localparam int RSH  = (FRAC >= 15) ? 0 : 15 - FRAC;
    localparam int HALF_IN = (RSH > 0) ? (1 << (RSH - 1)) : 0;
    localparam int PW   = IW + TW;
    localparam int SW   = PW + 2;
    localparam int MW   = IW + 25;
    localparam int XW   = MW + 8;

    logic [31:0]        smp_mem [MAX_POINTS];
    logic [2*IW-1:0]    wk_mem  [MAX_POINTS];
    logic [31:0]        smp_q_reg;
    logic [2*IW-1:0]    rd_a_reg;
    logic [2*IW-1:0]    rd_b_reg;

    logic signed [TW-1:0] wr_reg;
    logic signed [TW-1:0] wi_reg;
    logic signed [TW-1:0] wr_next;
    logic signed [TW-1:0] wi_next;
    logic signed [TW-1:0] sn;

    logic signed [PW-1:0] p_rr_reg;
    logic signed [PW-1:0] p_ii_reg;
    logic signed [PW-1:0] p_ri_reg;
    logic signed [PW-1:0] p_ir_reg;

    logic [2*IW-1:0]      diff_reg;
    logic [2*IW-1:0]      sum_w;
    logic [2*IW-1:0]      diff_next;
    logic [2*IW-1:0]      load_w;
    logic [2*IW-1:0]      wr_data;

    logic signed [IW:0]   sx_re;
    logic signed [IW:0]   sx_im;
    logic signed [IW:0]   in_re;
    logic signed [IW:0]   in_im;

    logic signed [IW-1:0] er;
    logic signed [IW-1:0] ei;
    logic signed [IW-1:0] br;
    logic signed [IW-1:0] bi;
    logic signed [SW-1:0] pr;
    logic signed [SW-1:0] pi;

    logic signed [MW-1:0] om_re_reg;
    logic signed [MW-1:0] om_im_reg;
    logic signed [24:0]   inv_sqrt2;
    logic [5:0]           oshift;
    logic signed [XW-1:0] ohalf;
    logic signed [XW-1:0] oy_re;
    logic signed [XW-1:0] oy_im;
    logic signed [15:0]   q_re;
    logic signed [15:0]   q_im;
    logic                 hit_re;
    logic                 hit_im;

    logic                 out_valid_reg;
    logic signed [15:0]   result_re_reg;
    logic signed [15:0]   result_im_reg;
    logic                 saturated_reg;
    logic                 last_bin_reg;

    function automatic logic [IW-1:0] sat_inner(input logic signed [SW-1:0] v);
        if (v[SW-1:IW-1] == '0 || v[SW-1:IW-1] == '1)
        begin
            return v[IW-1:0];
        end
        return v[SW-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    endfunction

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.smp_wr_en)
        begin
            smp_mem[cmd.smp_wr_addr[AW-1:0]] <= {sample_re, sample_im};
        end
        smp_q_reg <= smp_mem[cmd.smp_rd_addr[AW-1:0]];
        if (cmd.wk_wr_en)
        begin
            wk_mem[cmd.wk_wr_addr[AW-1:0]] <= wr_data;
        end
        rd_a_reg <= wk_mem[cmd.rd_a[AW-1:0]];
        rd_b_reg <= wk_mem[cmd.rd_b[AW-1:0]];
    end

    // load path: input format to inner format
    always_comb
    begin
        sx_re  = (IW+1)'(signed'(smp_q_reg[31:16]));
        sx_im  = (IW+1)'(signed'(smp_q_reg[15:0]));
        in_re  = ((sx_re + (IW+1)'(HALF_IN)) >>> RSH) <<< LSH;
        in_im  = ((sx_im + (IW+1)'(HALF_IN)) >>> RSH) <<< LSH;
        load_w = cmd.ld_zero ? '0 : {in_re[IW-1:0], in_im[IW-1:0]};
    end

    // twiddles
    always_comb
    begin
        wr_next = TW'(rfft_pkg::tw_cos(cmd.tw_idx, TW));
        sn      = TW'(rfft_pkg::tw_cos(cmd.tw_idx + 6'd48, TW));
        wi_next = inverse ? sn : -sn;
    end

    // butterfly
    always_comb
    begin
        er = signed'(rd_a_reg[2*IW-1:IW]);
        ei = signed'(rd_a_reg[IW-1:0]);
        br = signed'(rd_b_reg[2*IW-1:IW]);
        bi = signed'(rd_b_reg[IW-1:0]);
        pr = (SW'(p_rr_reg) - SW'(p_ii_reg) + SW'(1 << (TW - 2))) >>> (TW - 1);
        pi = (SW'(p_ri_reg) + SW'(p_ir_reg) + SW'(1 << (TW - 2))) >>> (TW - 1);
        sum_w     = {sat_inner(SW'(er) + pr), sat_inner(SW'(ei) + pi)};
        diff_next = {sat_inner(SW'(er) - pr), sat_inner(SW'(ei) - pi)};
    end

    always_comb
    begin
        case (cmd.wk_sel)
            rfft_pkg::WSEL_SUM:  wr_data = sum_w;
            rfft_pkg::WSEL_DIFF: wr_data = diff_reg;
            default:             wr_data = load_w;
        endcase
    end

    always_ff @(posedge clk)
    begin
        wr_reg <= wr_next;
        wi_reg <= wi_next;
        if (cmd.mul_en)
        begin
            p_rr_reg <= br * wr_reg;
            p_ii_reg <= bi * wi_reg;
            p_ri_reg <= br * wi_reg;
            p_ir_reg <= bi * wr_reg;
        end
        if (cmd.diff_en)
        begin
            diff_reg <= diff_next;
        end
        if (cmd.out_mul_en)
        begin
            if (lg[0])
            begin
                om_re_reg <= er * inv_sqrt2;
                om_im_reg <= ei * inv_sqrt2;
            end
            else
            begin
                om_re_reg <= MW'(er);
                om_im_reg <= MW'(ei);
            end
        end
    end

    // output scaling, round half up and clip to Q1.15
    always_comb
    begin
        inv_sqrt2 = 25'(rfft_pkg::INV_SQRT2_Q23);
        oshift = 6'(IW - 18) + 6'(lg >> 1) + (lg[0] ? 6'd23 : 6'd0);
        ohalf  = (oshift != 6'd0) ? (XW'(1) <<< (oshift - 6'd1)) : '0;
        oy_re  = ((XW'(om_re_reg) <<< 6) + ohalf) >>> oshift;
        oy_im  = ((XW'(om_im_reg) <<< 6) + ohalf) >>> oshift;
        hit_re = !(oy_re[XW-1:15] == '0 || oy_re[XW-1:15] == '1);
        hit_im = !(oy_im[XW-1:15] == '0 || oy_im[XW-1:15] == '1);
        q_re   = hit_re ? (oy_re[XW-1] ? 16'sh8000 : 16'sh7fff) : oy_re[15:0];
        q_im   = hit_im ? (oy_im[XW-1] ? 16'sh8000 : 16'sh7fff) : oy_im[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_re_reg <= q_re;
            result_im_reg <= q_im;
            saturated_reg <= hit_re | hit_im;
            last_bin_reg  <= cmd.last;
        end
    end

    assign out_valid        = out_valid_reg;
    assign result_re        = result_re_reg;
    assign result_im        = result_im_reg;
    assign saturated        = saturated_reg;
    assign last_bin         = last_bin_reg;
    assign status.out_valid = out_valid_reg;

endmodule

/* rtl/core/radix2_fft_unitary.sv */
// Channel   | Handshake            | Payload
// ----------+----------------------+------------------------------------------
// input     | in_valid / in_ready  | sample_re, sample_im, frame_end
// output    | out_valid / out_ready| result_re, result_im, saturated, last_bin
// config    | cfg_wr_en            | cfg_index, cfg_data
//
// Samples are taken at one per cycle while no transform runs. A request with
// frame_end starts the transform: load, N/2*log2(N) butterflies in turn on the
// shared butterfly unit (read, multiply, write A, write B), then the bins one by
// one: the held bin must drain before the next one is read and scaled.
// Reset resets control and config state, fill count and output valid at once.
// A stalled output holds its bin; the next bin waits in the work memory.
// After the last bin is loaded the block takes samples of the next frame.
module radix2_fft_unitary #(
    parameter int MAX_POINTS    = rfft_pkg::MAX_POINTS_DEF,
    parameter int INNER_WIDTH   = rfft_pkg::INNER_WIDTH_DEF,
    parameter int TWIDDLE_WIDTH = rfft_pkg::TWIDDLE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [0:0]         cfg_index,
    input  logic [2:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] sample_re,
    input  logic signed [15:0] sample_im,
    input  logic               frame_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] result_re,
    output logic signed [15:0] result_im,
    output logic               saturated,
    output logic               last_bin
);

    // largest length that fits the store
    localparam int LG_MAX = $clog2(MAX_POINTS + 1) - 1;

    logic                      inverse_reg;
    logic [2:0]                log2_size_reg;
    logic [rfft_pkg::LG_W-1:0] lg_eff;
    rfft_pkg::cmd_t            cmd;
    rfft_pkg::status_t         status;

    // hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverse_reg   <= 1'b0;
            log2_size_reg <= 3'd3;
        end
        else if (cfg_wr_en)
        begin
            case (rfft_pkg::cfg_idx_t'(cfg_index))
                rfft_pkg::CFG_INVERSE:   inverse_reg   <= cfg_data[0];
                rfft_pkg::CFG_LOG2_SIZE: log2_size_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // clamp the length code: zero acts as one, seven as six, then cap to the store
    always_comb
    begin
        lg_eff = log2_size_reg;
        if (lg_eff == 3'd0)
        begin
            lg_eff = 3'd1;
        end
        if (lg_eff == 3'd7)
        begin
            lg_eff = 3'd6;
        end
        if (lg_eff > 3'(LG_MAX))
        begin
            lg_eff = 3'(LG_MAX);
        end
    end

    rfft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .frame_end (frame_end),
        .lg        (lg_eff),
        .status    (status),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    rfft_dp #(
        .MAX_POINTS    (MAX_POINTS),
        .INNER_WIDTH   (INNER_WIDTH),
        .TWIDDLE_WIDTH (TWIDDLE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sample_re (sample_re),
        .sample_im (sample_im),
        .inverse   (inverse_reg),
        .lg        (lg_eff),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .result_re (result_re),
        .result_im (result_im),
        .saturated (saturated),
        .last_bin  (last_bin),
        .status    (status)
    );

endmodule
